[sv/lrukv_pkg.sv]
// Shared types and constants of the LRU key-value cache.
`timescale 1ns / 1ps
package lrukv_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int CAP_W   = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
    localparam logic signed [31:0] MISS_VALUE = -32'sd1;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [IDX_W-1:0] rank_t;

    typedef struct packed {
        logic               opcode;
        logic signed [31:0] lookup_key;
        logic signed [31:0] write_value;
    } req_word_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] read_value;
    } rsp_word_t;

    typedef struct packed {
        logic signed [31:0] key;
        logic signed [31:0] value;
    } entry_t;

    typedef enum logic [1:0] {
        RK_NONE,
        RK_TOUCH,
        RK_INSERT
    } rank_op_t;

    typedef struct packed {
        rank_op_t op;
        idx_t     slot;
        rank_t    slot_rank;
        rank_t    evict_level;
    } rank_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY
    } state_t;

endpackage

[sv/lrukv_ram.sv]
// Key and value storage: one write port, one registered read port.
`timescale 1ns / 1ps
module lrukv_ram (
    input  logic              clk,
    input  logic              we,
    input  lrukv_pkg::idx_t   waddr,
    input  lrukv_pkg::entry_t wdata,
    input  lrukv_pkg::idx_t   raddr,
    output lrukv_pkg::entry_t rdata
);

    lrukv_pkg::entry_t mem [lrukv_pkg::ENTRIES];
    lrukv_pkg::entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/lrukv_rank.sv]
// Valid bits and recency ranks of all slots, updated in parallel.
`timescale 1ns / 1ps
module lrukv_rank (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  lrukv_pkg::rank_cmd_t                  cmd,
    output logic [lrukv_pkg::ENTRIES-1:0]         valid,
    output lrukv_pkg::rank_t                      ranks [lrukv_pkg::ENTRIES]
);

    logic [lrukv_pkg::ENTRIES-1:0] valid_reg;
    logic [lrukv_pkg::ENTRIES-1:0] valid_next;
    lrukv_pkg::rank_t              rank_reg  [lrukv_pkg::ENTRIES];
    lrukv_pkg::rank_t              rank_next [lrukv_pkg::ENTRIES];

    always_comb
    begin
        for (int i = 0; i < lrukv_pkg::ENTRIES; i++)
        begin
            valid_next[i] = valid_reg[i];
            rank_next[i]  = rank_reg[i];
            unique case (cmd.op)
                lrukv_pkg::RK_TOUCH:
                begin
                    if (lrukv_pkg::idx_t'(i) == cmd.slot)
                    begin
                        rank_next[i] = '0;
                    end
                    else if (valid_reg[i] && rank_reg[i] < cmd.slot_rank)
                    begin
                        rank_next[i] = rank_reg[i] + 1'b1;
                    end
                end
                lrukv_pkg::RK_INSERT:
                begin
                    // drop slots past the capacity, age the rest, place the new one
                    if (lrukv_pkg::idx_t'(i) == cmd.slot)
                    begin
                        valid_next[i] = 1'b1;
                        rank_next[i]  = '0;
                    end
                    else if (valid_reg[i] && rank_reg[i] >= cmd.evict_level)
                    begin
                        valid_next[i] = 1'b0;
                        rank_next[i]  = '0;
                    end
                    else if (valid_reg[i])
                    begin
                        rank_next[i] = rank_reg[i] + 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            for (int i = 0; i < lrukv_pkg::ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg <= valid_next;
            for (int i = 0; i < lrukv_pkg::ENTRIES; i++)
            begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    assign valid = valid_reg;
    assign ranks = rank_reg;

endmodule

[sv/lru_key_value_cache.sv]
// Top level of the LRU key-value cache: scan sequencer, shared key compare, result register.
//
// Usage:
//   req (valid/ready) carries one word: opcode (get or put), lookup_key, write_value.
//   rsp (valid/ready) carries hit and read_value; one word per get, none per put.
//   cfg_we/cfg_data write the capacity register (reset 16, values above 16 act as 16,
//   zero makes puts do nothing). Write it only while the block is idle.
// Sequence:
//   req_ready drops at acceptance and rises again once the word is done: 16 key compares,
//   one per slot, behind the registered storage read, then the update of ranks and storage,
//   so a new word is taken only after the last one is through.
//   A get result appears in the rsp register at the end of the update cycle.
// Stall:
//   The rsp register holds a finished result while the next word is scanned; a
//   get that finishes while an earlier result is still untaken waits in its
//   update cycle until rsp_ready frees the register.
// Reset:
//   rst_n clears all valid bits and ranks (the store is empty) and sets capacity
//   to 16; storage contents need no reset.
`timescale 1ns / 1ps
module lru_key_value_cache (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_ready,
    input  lrukv_pkg::req_word_t               req,
    output logic                               rsp_valid,
    input  logic                               rsp_ready,
    output lrukv_pkg::rsp_word_t               rsp,
    input  logic                               cfg_we,
    input  logic [lrukv_pkg::CAP_W-1:0]        cfg_data
);

    lrukv_pkg::state_t               state_reg, state_next;
    logic [lrukv_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    lrukv_pkg::req_word_t            item_reg, item_next;
    logic                            match_reg, match_next;
    lrukv_pkg::idx_t                 match_slot_reg, match_slot_next;
    lrukv_pkg::rank_t                match_rank_reg, match_rank_next;
    logic signed [31:0]              match_value_reg, match_value_next;
    logic                            free_found_reg, free_found_next;
    lrukv_pkg::idx_t                 free_slot_reg, free_slot_next;
    lrukv_pkg::rsp_word_t            rsp_reg, rsp_next;
    logic                            rsp_valid_reg, rsp_valid_next;
    logic [lrukv_pkg::CAP_W-1:0]     cap_reg;

    logic [lrukv_pkg::CAP_W-1:0]     cap_eff;
    lrukv_pkg::rank_t                evict_level;
    lrukv_pkg::idx_t                 cmp_idx;
    logic                            cmp_active;
    logic                            key_hit;
    logic                            slot_free;

    logic                            ram_we;
    lrukv_pkg::idx_t                 ram_waddr;
    lrukv_pkg::entry_t               ram_wdata;
    lrukv_pkg::entry_t               ram_rdata;
    lrukv_pkg::rank_cmd_t            rank_cmd;
    logic [lrukv_pkg::ENTRIES-1:0]   valid_vec;
    lrukv_pkg::rank_t                rank_vec [lrukv_pkg::ENTRIES];

    lrukv_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (cnt_reg[lrukv_pkg::IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    lrukv_rank u_rank (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (rank_cmd),
        .valid (valid_vec),
        .ranks (rank_vec)
    );

    assign cap_eff = (cap_reg > lrukv_pkg::CAP_W'(lrukv_pkg::ENTRIES))
                   ? lrukv_pkg::CAP_W'(lrukv_pkg::ENTRIES) : cap_reg;
    assign evict_level = lrukv_pkg::IDX_W'(cap_eff - 1'b1);

    // storage data is registered, so it belongs to the previous read address
    assign cmp_idx    = cnt_reg[lrukv_pkg::IDX_W-1:0] - 1'b1;
    assign cmp_active = (state_reg == lrukv_pkg::ST_SCAN) && (cnt_reg != '0);
    assign key_hit    = valid_vec[cmp_idx] && (ram_rdata.key == item_reg.lookup_key);
    assign slot_free  = !valid_vec[cmp_idx] || (rank_vec[cmp_idx] >= evict_level);

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        item_next        = item_reg;
        match_next       = match_reg;
        match_slot_next  = match_slot_reg;
        match_rank_next  = match_rank_reg;
        match_value_next = match_value_reg;
        free_found_next  = free_found_reg;
        free_slot_next   = free_slot_reg;
        rsp_next         = rsp_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp_ready;
        ram_we           = 1'b0;
        ram_waddr        = match_slot_reg;
        ram_wdata        = '{key: item_reg.lookup_key, value: item_reg.write_value};
        rank_cmd         = '{op: lrukv_pkg::RK_NONE, slot: match_slot_reg,
                             slot_rank: match_rank_reg, evict_level: evict_level};
        req_ready        = 1'b0;

        unique case (state_reg)
            lrukv_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    item_next       = req;
                    cnt_next        = '0;
                    match_next      = 1'b0;
                    free_found_next = 1'b0;
                    state_next      = lrukv_pkg::ST_SCAN;
                end
            end
            lrukv_pkg::ST_SCAN:
            begin
                if (cmp_active)
                begin
                    if (key_hit && !match_reg)
                    begin
                        match_next       = 1'b1;
                        match_slot_next  = cmp_idx;
                        match_rank_next  = rank_vec[cmp_idx];
                        match_value_next = ram_rdata.value;
                    end
                    if (slot_free && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_slot_next  = cmp_idx;
                    end
                end
                if (cnt_reg == lrukv_pkg::CNT_W'(lrukv_pkg::ENTRIES))
                begin
                    state_next = lrukv_pkg::ST_APPLY;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            lrukv_pkg::ST_APPLY:
            begin
                if (item_reg.opcode == lrukv_pkg::OP_GET)
                begin
                    // hold until the result register is free
                    if (!rsp_valid_reg || rsp_ready)
                    begin
                        if (match_reg)
                        begin
                            rank_cmd.op = lrukv_pkg::RK_TOUCH;
                            rsp_next    = '{hit: 1'b1, read_value: match_value_reg};
                        end
                        else
                        begin
                            rsp_next = '{hit: 1'b0, read_value: lrukv_pkg::MISS_VALUE};
                        end
                        rsp_valid_next = 1'b1;
                        state_next     = lrukv_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    if (cap_eff != '0)
                    begin
                        ram_we = 1'b1;
                        if (match_reg)
                        begin
                            rank_cmd.op = lrukv_pkg::RK_TOUCH;
                        end
                        else
                        begin
                            ram_waddr     = free_slot_reg;
                            rank_cmd.op   = lrukv_pkg::RK_INSERT;
                            rank_cmd.slot = free_slot_reg;
                        end
                    end
                    state_next = lrukv_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lrukv_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lrukv_pkg::ST_IDLE;
            rsp_valid_reg <= 1'b0;
            cap_reg       <= lrukv_pkg::CAP_RESET;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            cnt_reg       <= cnt_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg        <= item_next;
        match_reg       <= match_next;
        match_slot_reg  <= match_slot_next;
        match_rank_reg  <= match_rank_next;
        match_value_reg <= match_value_next;
        free_found_reg  <= free_found_next;
        free_slot_reg   <= free_slot_next;
        rsp_reg         <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
